// ===== rtl/ultrasonic_echo_ranger_top_assert.svh =====
// Assertion macros shared by the ranger modules
`ifndef ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define UER_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("uer assertion failed");

// Check that a condition implies another in the next cycle
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("uer assertion failed");

`endif

// ===== rtl/uer_pkg.sv =====
// Package: shared constants, codes and control structs of the echo ranger
package uer_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIST_W     = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CM_DIVIDER    = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd15;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd38000;
    localparam logic [7:0]  CM_DIVIDER_RST    = 8'd58;

    localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

    // Measurement phase codes
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TRIG      = 3'd1;
    localparam logic [2:0] PH_WAIT_RISE = 3'd2;
    localparam logic [2:0] PH_ECHO_HIGH = 3'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic div_run;
        logic push;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_sts;

endpackage

// ===== rtl/uer_in_if.sv =====
// Interface: input item channel (tick or start command plus echo level)
interface uer_in_if;
    logic valid;
    logic ready;
    logic cmd;
    logic echo_level;

    modport source(output valid, output cmd, output echo_level, input ready);
    modport sink(input valid, input cmd, input echo_level, output ready);
endinterface

// ===== rtl/uer_out_if.sv =====
// Interface: result item channel (pin level, status flags and distance)
interface uer_out_if;
    logic        valid;
    logic        ready;
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [15:0] distance_cm;

    modport source(output valid, output trigger_level, output busy_res, output done_res,
                   output timed_out, output distance_cm, input ready);
    modport sink(input valid, input trigger_level, input busy_res, input done_res,
                 input timed_out, input distance_cm, output ready);
endinterface

// ===== rtl/uer_ctrl.sv =====
// Controller: sequences accept, evaluate, divide and result push per item
`include "ultrasonic_echo_ranger_top_assert.svh"
module uer_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output uer_pkg::t_cmd o_cmd,
    input  uer_pkg::t_sts i_sts
);
    import uer_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       accept;

    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = i_in_valid && (r_state == S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_sts.need_div ? S_DIV : S_PUSH;
            end
            S_DIV: begin
                if (i_sts.div_last) n_state = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output register valid: set on push, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_PUSH && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Commands
    assign o_cmd.load    = accept;
    assign o_cmd.eval    = (r_state == S_EVAL);
    assign o_cmd.div_run = (r_state == S_DIV);
    assign o_cmd.push    = (r_state == S_PUSH) && out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `UER_ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n, accept, r_state == S_EVAL)
    `UER_ASSERT_NEXT(a_div_hold, i_clk, i_rst_n, (r_state == S_DIV) && !i_sts.div_last, r_state == S_DIV)
    `UER_ASSERT_NEXT(a_push_valid, i_clk, i_rst_n, (r_state == S_PUSH) && out_free, r_out_valid)

endmodule

// ===== rtl/uer_dp.sv =====
// Datapath: configuration, measurement counters, serial divider, result register
`include "ultrasonic_echo_ranger_top_assert.svh"
module uer_dp #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_cmd,
    input  logic                           i_echo_level,
    input  uer_pkg::t_cmd                  i_ctl,
    output uer_pkg::t_sts                  o_sts,
    output logic                           o_trigger_level,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic                           o_timed_out,
    output logic [uer_pkg::DIST_W-1:0]     o_distance_cm
);
    import uer_pkg::*;

    localparam int DCW = $clog2(COUNT_WIDTH);
    localparam int QW  = (COUNT_WIDTH > DIST_W) ? COUNT_WIDTH : DIST_W;

    // Configuration
    logic [7:0]  r_cfg_trig;
    logic [15:0] r_cfg_tmo;
    logic [7:0]  r_cfg_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_trig <= TRIGGER_TICKS_RST;
            r_cfg_tmo  <= TIMEOUT_TICKS_RST;
            r_cfg_div  <= CM_DIVIDER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRIGGER_TICKS: r_cfg_trig <= i_cfg_data[7:0];
                CFG_TIMEOUT_TICKS: r_cfg_tmo  <= i_cfg_data[15:0];
                CFG_CM_DIVIDER:    r_cfg_div  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Latch the accepted item
    logic r_in_cmd, r_in_echo;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_in_cmd  <= i_cmd;
            r_in_echo <= i_echo_level;
        end
    end

    // Measurement state
    logic [2:0]             r_phase, n_phase;
    logic [7:0]             r_tc, n_tc;
    logic [15:0]            r_wc, n_wc;
    logic [COUNT_WIDTH-1:0] r_ec, n_ec;
    logic [DIST_W-1:0]      r_dist;
    logic                   r_done, r_tmo;
    logic                   fin, tmo;

    // Advance the measurement by one item
    always_comb begin
        n_phase = r_phase;
        n_tc    = r_tc;
        n_wc    = r_wc;
        n_ec    = r_ec;
        fin     = 1'b0;
        tmo     = 1'b0;
        if (r_in_cmd) begin
            if (r_phase == PH_IDLE) begin
                n_phase = PH_TRIG;
                n_tc    = '0;
                n_wc    = '0;
                n_ec    = '0;
            end
        end else if (r_phase == PH_TRIG) begin
            if (r_tc != 8'hFF) n_tc = r_tc + 8'd1;
            if (n_tc >= r_cfg_trig) n_phase = PH_WAIT_RISE;
        end else if (r_phase == PH_WAIT_RISE || r_phase == PH_ECHO_HIGH) begin
            if (r_wc != 16'hFFFF) n_wc = r_wc + 16'd1;
            if (r_phase == PH_WAIT_RISE) begin
                if (r_in_echo) begin
                    n_phase = PH_ECHO_HIGH;
                    n_ec    = COUNT_WIDTH'(1);
                end
            end else if (r_in_echo) begin
                if (r_ec != {COUNT_WIDTH{1'b1}}) n_ec = r_ec + COUNT_WIDTH'(1);
            end else begin
                fin = 1'b1;
            end
            if (!fin && n_wc >= r_cfg_tmo) begin
                fin = 1'b1;
                tmo = 1'b1;
            end
            if (fin) n_phase = PH_IDLE;
        end
    end

    // Restoring divider, one quotient bit a cycle
    logic [7:0]             r_rem, n_rem;
    logic [COUNT_WIDTH-1:0] r_quo, n_quo;
    logic [DCW-1:0]         r_dcnt;
    logic [8:0]             shifted, diff;
    logic                   ge;
    logic [QW-1:0]          q_ext;
    logic [DIST_W-1:0]      q_sat;

    assign shifted = {r_rem, r_quo[COUNT_WIDTH-1]};
    assign ge      = shifted >= {1'b0, r_cfg_div};
    assign diff    = shifted - {1'b0, r_cfg_div};
    assign n_rem   = ge ? diff[7:0] : shifted[7:0];
    assign n_quo   = {r_quo[COUNT_WIDTH-2:0], ge};
    assign q_ext   = QW'(n_quo);
    assign q_sat   = (q_ext > QW'(DIST_MAX)) ? DIST_MAX : q_ext[DIST_W-1:0];

    assign o_sts.need_div = fin;
    assign o_sts.div_last = (r_dcnt == DCW'(COUNT_WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_ctl.eval && fin) begin
            r_quo  <= n_ec;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_ctl.div_run) begin
            r_quo  <= n_quo;
            r_rem  <= n_rem;
            r_dcnt <= r_dcnt + DCW'(1);
        end
    end

    // Commit measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tc    <= '0;
            r_wc    <= '0;
            r_ec    <= '0;
            r_dist  <= '0;
            r_done  <= 1'b0;
            r_tmo   <= 1'b0;
        end else begin
            if (i_ctl.eval) begin
                r_phase <= n_phase;
                r_tc    <= n_tc;
                r_wc    <= n_wc;
                r_ec    <= n_ec;
                r_done  <= fin;
                r_tmo   <= tmo;
            end
            if (i_ctl.div_run && o_sts.div_last) begin
                r_dist <= (r_cfg_div == 8'd0) ? DIST_MAX : q_sat;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            o_trigger_level <= (r_phase == PH_TRIG);
            o_busy_res      <= (r_phase != PH_IDLE);
            o_done_res      <= r_done;
            o_timed_out     <= r_tmo;
            o_distance_cm   <= r_dist;
        end
    end

    `UER_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, r_done, r_phase == PH_IDLE)
    `UER_ASSERT_SAME(a_tmo_done, i_clk, i_rst_n, r_tmo, r_done)
    `UER_ASSERT_SAME(a_echo_nonzero, i_clk, i_rst_n, r_phase == PH_ECHO_HIGH, r_ec != '0)

endmodule

// ===== rtl/ultrasonic_echo_ranger_top.sv =====
// Top level: ultrasonic echo-pulse range finder
//
//  channel   dir  port     payload
//  items in  in   i_in     cmd, echo_level
//  results   out  o_out    trigger_level, busy_res, done_res, timed_out, distance_cm
//  config    in   i_cfg_*  we, idx (0 trigger, 1 timeout, 2 divider), 16-bit data
//
// An item holds the block through accept, evaluate and push, its result registered
// at the push; one that ends a measurement also runs the one-bit-a-cycle divider.
// Reset is synchronous, active low; it restores the configuration defaults.
// A waiting result does not block the next accept: the next item is worked and
// held until the output register frees.
module ultrasonic_echo_ranger_top #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    uer_in_if.sink                         i_in,
    uer_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import uer_pkg::*;

    t_cmd ctl;
    t_sts sts;

    // Sequencer
    uer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (ctl),
        .i_sts       (sts)
    );

    // Counters, divider and result register
    uer_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_in.cmd),
        .i_echo_level    (i_in.echo_level),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .o_trigger_level (o_out.trigger_level),
        .o_busy_res      (o_out.busy_res),
        .o_done_res      (o_out.done_res),
        .o_timed_out     (o_out.timed_out),
        .o_distance_cm   (o_out.distance_cm)
    );

endmodule
